// ===== hw/rtl/rli_pkg.sv =====
// Shared types, constants and helpers for the RGB LUT interpolator.
// Used by rli_lut_ram, rli_channel and rgb_lut_interpolator; depends on nothing.
`default_nettype none

package rli_pkg;

  // Table geometry
  localparam int unsigned MAX_ENTRIES_DEF = 4096;
  localparam int unsigned DATA_W          = 16;
  localparam int unsigned ADDR_W_MAX      = 16;   // address bits at the largest depth
  localparam int unsigned LEN_W           = 17;   // holds a length of up to 65536

  localparam logic [12:0] RESET_ENTRIES = 13'd256;

  // Fixed-point scale: 65535 stands for 1.0
  localparam logic [16:0] FULL_SCALE = 17'd65535;
  localparam logic [15:0] HALF_SCALE = 16'd32767;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Table select codes
  localparam logic [1:0] TBL_RED   = 2'd0;
  localparam logic [1:0] TBL_GREEN = 2'd1;
  localparam logic [1:0] TBL_BLUE  = 2'd2;

  // Control handed from the top level to one channel
  typedef struct packed {
    logic                  pix_rd;   // pixel in the table-read stage
    logic                  wr_en;    // load write to this channel's table
    logic [ADDR_W_MAX-1:0] wr_addr;
    logic [DATA_W-1:0]     wr_data;
  } ctl_t;

  // Clamp a programmed entry count to 1..max_n and return count minus one.
  function automatic logic [ADDR_W_MAX-1:0] len_m1_of(input logic [12:0] n,
                                                      input logic [LEN_W-1:0] max_n);
    logic [LEN_W-1:0] len;
    len = {4'd0, n};
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > max_n) begin
      len = max_n;
    end
    return ADDR_W_MAX'(len - LEN_W'(1));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rli_lut_ram.sv =====
// One table memory: one write port, two read ports, read data registered.
// Depends on rli_pkg for the data width.
`default_nettype none

module rli_lut_ram #(
  parameter int unsigned DEPTH = rli_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [rli_pkg::DATA_W-1:0]  wr_data_i,
  input  wire logic [AW-1:0]               rd_addr_a_i,
  input  wire logic [AW-1:0]               rd_addr_b_i,
  output logic      [rli_pkg::DATA_W-1:0]  rd_data_a_o,
  output logic      [rli_pkg::DATA_W-1:0]  rd_data_b_o
);

  logic [rli_pkg::DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rli_channel.sv =====
// One color channel: index split, table memory read and the rounded linear blend.
// Depends on rli_pkg and rli_lut_ram.
`default_nettype none

module rli_channel #(
  parameter int unsigned MAX_ENTRIES = rli_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW         = $clog2(MAX_ENTRIES)
) (
  input  wire logic                        clk_i,
  input  wire logic [AW-1:0]               len_m1_i,
  input  wire logic [15:0]                 pix_i,
  input  wire rli_pkg::ctl_t               ctl_i,
  output logic      [15:0]                 out_o
);

  localparam int unsigned SW = 16 + AW;

  logic [SW-1:0]        scaled_q;
  logic [AW-1:0]        whole;
  logic [16:0]          fold;
  logic                 wrap;
  logic [AW-1:0]        lo_idx;
  logic [AW-1:0]        hi_idx;
  logic [15:0]          rem_d, rem_q;
  logic [15:0]          rd_lo, rd_hi;
  logic signed [16:0]   diff;
  logic signed [33:0]   prod_d, prod_q;
  logic [15:0]          base_q;
  logic signed [33:0]   sum_s;
  logic [31:0]          sum_q;
  logic [16:0]          fold2;
  logic [15:0]          out_d;

  // Split scaled = whole*65536 + frac into quotient and remainder by 65535.
  always_comb begin
    whole  = scaled_q[SW-1:16];
    fold   = {1'b0, scaled_q[15:0]} + 17'(whole);
    wrap   = fold >= rli_pkg::FULL_SCALE;
    lo_idx = wrap ? AW'(whole + AW'(1)) : whole;
    rem_d  = wrap ? 16'(fold - rli_pkg::FULL_SCALE) : fold[15:0];
    hi_idx = (lo_idx == len_m1_i) ? lo_idx : AW'(lo_idx + AW'(1));
  end

  rli_lut_ram #(
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (ctl_i.wr_en),
    .wr_addr_i   (ctl_i.wr_addr[AW-1:0]),
    .wr_data_i   (ctl_i.wr_data),
    .rd_addr_a_i (lo_idx),
    .rd_addr_b_i (hi_idx),
    .rd_data_a_o (rd_lo),
    .rd_data_b_o (rd_hi)
  );

  // Blend as a*65535 + (b-a)*r, one multiply.
  always_comb begin
    diff   = $signed({1'b0, rd_hi}) - $signed({1'b0, rd_lo});
    prod_d = 34'(diff) * 34'($signed({1'b0, rem_q}));
    sum_s  = $signed({2'b00, base_q, 16'h0000}) - $signed({18'd0, base_q})
             + prod_q + $signed({18'd0, rli_pkg::HALF_SCALE});
    fold2  = {1'b0, sum_q[15:0]} + {1'b0, sum_q[31:16]};
    out_d  = (fold2 >= rli_pkg::FULL_SCALE) ? 16'(sum_q[31:16] + 16'd1) : sum_q[31:16];
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= SW'(pix_i) * SW'(len_m1_i);
    rem_q    <= rem_d;
    prod_q   <= prod_d;
    base_q   <= rd_lo;
    sum_q    <= sum_s[31:0];
    out_o    <= out_d;
  end

  // Neighbor picks stay inside the active table and one apart at most.
  assert property (@(posedge clk_i) ctl_i.pix_rd |->
                   (hi_idx <= len_m1_i) && (lo_idx <= hi_idx) &&
                   ((hi_idx == lo_idx) || (hi_idx == AW'(lo_idx + AW'(1)))))
    else $error("rli_channel: neighbor index out of range");

  // A load write never shares the read stage with a pixel.
  assert property (@(posedge clk_i) ctl_i.wr_en |-> !ctl_i.pix_rd)
    else $error("rli_channel: table write collides with pixel read");

  // The blend weight is a true remainder of 65535.
  assert property (@(posedge clk_i) $past(ctl_i.pix_rd) |-> (rem_q != 16'hFFFF))
    else $error("rli_channel: remainder reached full scale");

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_lut_interpolator.sv =====
// RGB LUT interpolator top level: transfer accept, config register, control pipe.
// Depends on rli_pkg and rli_channel (which holds rli_lut_ram).
// Throughput: one item per clock; busy is never raised. A pixel's result shows with
// done_o high once it has passed the multiply, memory read, blend multiply, sum and
// divide registers, in that order.
// Reset clears the pipeline flags and sets the active table length to 256 entries; tables are not cleared.
`default_nettype none

module rgb_lut_interpolator #(
  parameter int unsigned MAX_ENTRIES = rli_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [1:0]  table_select_i,
  input  wire logic [11:0] entry_index_i,
  input  wire logic [15:0] entry_value_i,
  input  wire logic [15:0] red_in_i,
  input  wire logic [15:0] green_in_i,
  input  wire logic [15:0] blue_in_i,
  // configuration write
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  // results
  output logic             done_o,
  output logic [15:0]      red_out_o,
  output logic [15:0]      green_out_o,
  output logic [15:0]      blue_out_o
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned DEPTH = 5;   // acceptance edge to result register
  localparam logic [rli_pkg::LEN_W-1:0] MAX_W = rli_pkg::LEN_W'(MAX_ENTRIES);
  localparam logic [rli_pkg::ADDR_W_MAX-1:0] RST_LM1 =
    rli_pkg::len_m1_of(rli_pkg::RESET_ENTRIES, MAX_W);

  logic                                 accept;
  logic                                 in_range;
  logic [rli_pkg::ADDR_W_MAX-1:0]       cfg_lm1;
  logic [AW-1:0]                        len_m1_q;
  logic [DEPTH-1:0]                     pix_q, pix_d;
  logic [2:0]                           wr_en_q, wr_en_d;
  logic [rli_pkg::ADDR_W_MAX-1:0]       wr_addr_q;
  logic [15:0]                          wr_data_q;
  logic [15:0]                          pix_in  [3];
  logic [15:0]                          ch_out  [3];
  rli_pkg::ctl_t                        ctl     [3];

  // No stall source: the pipe moves every cycle and the receiver takes every result.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Drop loads whose index falls past the table depth.
  assign in_range = {5'd0, entry_index_i} < MAX_W;
  assign cfg_lm1  = rli_pkg::len_m1_of(cfg_wdata_i, MAX_W);

  always_comb begin
    pix_d      = {pix_q[DEPTH-2:0], accept && (operation_i == rli_pkg::OP_PIXEL)};
    wr_en_d[0] = accept && (operation_i == rli_pkg::OP_LOAD) && in_range &&
                 (table_select_i == rli_pkg::TBL_RED);
    wr_en_d[1] = accept && (operation_i == rli_pkg::OP_LOAD) && in_range &&
                 (table_select_i == rli_pkg::TBL_GREEN);
    wr_en_d[2] = accept && (operation_i == rli_pkg::OP_LOAD) && in_range &&
                 (table_select_i == rli_pkg::TBL_BLUE);
  end

  // Control state: pixel flags, load enables and the clamped length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q    <= '0;
      wr_en_q  <= '0;
      len_m1_q <= RST_LM1[AW-1:0];
    end else begin
      pix_q   <= pix_d;
      wr_en_q <= wr_en_d;
      if (cfg_we_i) begin
        len_m1_q <= cfg_lm1[AW-1:0];
      end
    end
  end

  // Hold the load payload one stage, so a table write lands in the same stage as
  // pixel reads and older pixels always see the table as it stood at their transfer.
  always_ff @(posedge clk_i) begin
    wr_addr_q <= {4'd0, entry_index_i};
    wr_data_q <= entry_value_i;
  end

  assign pix_in[0] = red_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = blue_in_i;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign ctl[c] = '{pix_rd:  pix_q[0],
                      wr_en:   wr_en_q[c],
                      wr_addr: wr_addr_q,
                      wr_data: wr_data_q};

    rli_channel #(
      .MAX_ENTRIES (MAX_ENTRIES)
    ) u_channel (
      .clk_i    (clk_i),
      .len_m1_i (len_m1_q),
      .pix_i    (pix_in[c]),
      .ctl_i    (ctl[c]),
      .out_o    (ch_out[c])
    );
  end

  assign done_o      = pix_q[DEPTH-1];
  assign red_out_o   = ch_out[0];
  assign green_out_o = ch_out[1];
  assign blue_out_o  = ch_out[2];

  // Every pixel transfer yields a result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && (operation_i == rli_pkg::OP_PIXEL)) |-> ##5 done_o)
    else $error("rgb_lut_interpolator: pixel result missing");

  // Loads never produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && (operation_i == rli_pkg::OP_LOAD)) |-> ##5 !done_o)
    else $error("rgb_lut_interpolator: load produced a result");

  // No result strobe without a pixel transfer behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> $past(accept && (operation_i == rli_pkg::OP_PIXEL), 5))
    else $error("rgb_lut_interpolator: result without pixel");

endmodule

`default_nettype wire
